// ===== rtl/dbam_pkg.sv =====
// Shared constants, types and opcodes for the DRAM bank access monitor.
// No dependencies.
`default_nettype none
package dbam_pkg;
	localparam int NUM_BANKS_D       = 128;
	localparam int LAYER_BANKS_D     = 16;
	localparam int BANK_BIT_OFFSET_D = 6;
	localparam int LAYER_BITS_D      = 3;

	localparam logic [1:0] OP_READ   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_SNAP   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] REG_ACC   = 2'd0;
	localparam logic [1:0] REG_DELAY = 2'd1;
	localparam logic [1:0] REG_ILV   = 2'd2;

	localparam logic [23:0] ACC_RESET   = 24'd1000;
	localparam logic [23:0] DELAY_RESET = 24'd20;
	localparam logic [10:0] ILV_RESET   = 11'd1;

	// Status handed from the divider unit.
	typedef struct packed {
		logic        busy;
		logic        done;
	} div_stat_t;
endpackage
`default_nettype wire

// ===== rtl/dram_bank_access_monitor_core.sv =====
// DRAM bank access monitor top: phase counters in one memory, snapshot in another.
// Depends on dbam_pkg and dbam_div.
// Sequence: ignored or unused beats raise done straight from idle; opcode 2 reads the
// snapshot in ST_SNAP; an access runs four divisions from ST_D1 to ST_OUT, and a snapshot adds the copy.
// Throughput: one beat at a time; busy drops in the strobe cycle. Receiver cannot stall.
// Reset: asynchronous, then a clearing pass of both memories with busy high.
`default_nettype none
module dram_bank_access_monitor_core
	import dbam_pkg::*;
#(
	parameter int NUM_BANKS       = NUM_BANKS_D,
	parameter int LAYER_BANKS     = LAYER_BANKS_D,
	parameter int BANK_BIT_OFFSET = BANK_BIT_OFFSET_D,
	parameter int LAYER_BITS      = LAYER_BITS_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic [1:0]  opcode,
	input  wire logic [47:0] mem_address,
	input  wire logic [9:0]  requester_id,
	input  wire logic [47:0] time_us,
	input  wire logic        in_region,
	input  wire logic [6:0]  bank_select,
	output logic             done,
	output logic             snapshot_taken,
	output logic             closed_phase,
	output logic [47:0]      interval_start,
	output logic [31:0]      closed_reads,
	output logic [31:0]      closed_writes,
	output logic [31:0]      closed_total,
	output logic [6:0]       bank_index,
	output logic [47:0]      skipped_intervals,
	output logic [31:0]      counter_value,
	output logic             bank_error
);
	localparam int BW = $clog2(NUM_BANKS);
	localparam int LW = $clog2(LAYER_BANKS * (1 << LAYER_BITS) + 1024);
	localparam int XW = (LW > BW) ? LW : BW;
	localparam int SD = 1 << BW;
	localparam int PD = 2 * SD;

	localparam logic [3:0] ST_IDLE = 4'd0, ST_SNAP = 4'd1, ST_D1 = 4'd2,
		ST_D2 = 4'd3, ST_D3 = 4'd4, ST_RD = 4'd5, ST_UPD = 4'd6,
		ST_D4 = 4'd7, ST_OUT = 4'd8, ST_COPY = 4'd9, ST_CRD = 4'd10,
		ST_CLR = 4'd11;

	logic [3:0]  st_q;
	logic [23:0] acc_q, dly_q;
	logic [10:0] ilv_q;
	logic [1:0]  op_q;
	logic [LAYER_BITS-1:0] layer_q;
	logic [9:0]  requester_id_q;
	logic [47:0] t_q;
	logic [6:0]  sel_q;
	logic [XW-1:0] bank_q;
	logic        err_q, two_q, rclosed_q;
	logic [47:0] pt_q, start_q;
	logic [31:0] r1_q, w1_q, r2_q, w2_q;
	logic        arm1_q, arm2_q;
	logic [47:0] last_q;
	logic [BW:0] cidx_q;

	// phase one counters in the low half, phase two in the high half
	logic [31:0] pcnt_mem [0:PD-1];
	logic [31:0] snap_mem [0:SD-1];
	logic [31:0] prd_q, srd_q;

	logic        div_go;
	logic [47:0] div_num, quo;
	logic [25:0] div_den, rem;
	div_stat_t   dstat;

	dbam_div #(.NW(48), .DW(26)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(div_num),
		.den(div_den), .stat(dstat), .quo(quo), .rem(rem)
	);

	logic [23:0] acc_e;
	logic [10:0] ilv_e;
	assign acc_e = (acc_q == '0) ? 24'd1 : acc_q;
	assign ilv_e = (ilv_q == '0) ? 11'd1 : ilv_q;

	logic [BW:0]   paddr;
	logic          two_c;
	logic [47:0]   adiff;
	logic [BW-1:0] saddr, copy_a;
	assign two_c  = pt_q > {24'd0, acc_e};
	assign paddr  = {two_c, bank_q[BW-1:0]};
	assign adiff  = start_q - last_q - 48'd1;
	assign saddr  = BW'((st_q == ST_IDLE) ? bank_select : sel_q);
	assign copy_a = cidx_q[BW-1:0] - BW'(1);

	always_comb begin
		div_go  = 1'b0;
		div_num = t_q;
		div_den = {2'b0, acc_e};
		unique case (st_q)
			ST_D1: begin
				div_num = {38'd0, requester_id_q};
				div_den = {15'd0, ilv_e};
			end
			ST_D2: div_den = {1'b0, acc_e, 1'b0};
			ST_D4: div_num = adiff;
			default: ;
		endcase
		if (st_q == ST_D1 || st_q == ST_D2 || st_q == ST_D3 || st_q == ST_D4)
			div_go = !dstat.busy && !dstat.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLR;
			acc_q  <= ACC_RESET;
			dly_q  <= DELAY_RESET;
			ilv_q  <= ILV_RESET;
			op_q <= '0; layer_q <= '0; requester_id_q <= '0; t_q <= '0;
			sel_q <= '0; bank_q <= '0; err_q <= 1'b0; two_q <= 1'b0;
			rclosed_q <= 1'b0; pt_q <= '0;
			r1_q <= '0; w1_q <= '0; r2_q <= '0; w2_q <= '0;
			arm1_q <= 1'b0;
			arm2_q <= 1'b1;
			last_q <= '0;
			cidx_q <= '0;
			done   <= 1'b0;
			snapshot_taken <= 1'b0; closed_phase <= 1'b0;
			interval_start <= '0; closed_reads <= '0;
			closed_writes <= '0; closed_total <= '0;
			bank_index <= '0; skipped_intervals <= '0;
			counter_value <= '0; bank_error <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_ACC:   acc_q <= cfg_data;
					REG_DELAY: dly_q <= cfg_data;
					REG_ILV:   ilv_q <= cfg_data[10:0];
					default: ;
				endcase
			end
			unique case (st_q)
				ST_CLR: begin
					cidx_q <= cidx_q + 1'b1;
					if (cidx_q == (BW+1)'(PD - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (start) begin
					op_q <= opcode; layer_q <= mem_address[BANK_BIT_OFFSET +: LAYER_BITS];
					requester_id_q <= requester_id; t_q <= time_us;
					sel_q <= bank_select;
					snapshot_taken <= 1'b0; closed_phase <= 1'b0;
					interval_start <= '0; closed_reads <= '0;
					closed_writes <= '0; closed_total <= '0;
					bank_index <= '0; skipped_intervals <= '0;
					counter_value <= '0; bank_error <= 1'b0;
					if (opcode == OP_SNAP) st_q <= ST_SNAP;
					else if (opcode == OP_READ || opcode == OP_WRITE) begin
						if (in_region) st_q <= ST_D1;
						else begin done <= 1'b1; end
					end else done <= 1'b1;
				end
				ST_SNAP: begin
					if ({25'd0, sel_q} < NUM_BANKS)
						counter_value <= srd_q;
					done <= 1'b1;
					st_q <= ST_IDLE;
				end
				ST_D1: if (dstat.done) begin
					bank_q <= XW'(layer_q) * XW'(LAYER_BANKS) + XW'(quo[9:0]);
					st_q <= ST_D2;
				end
				ST_D2: if (dstat.done) begin
					pt_q <= {22'd0, rem};
					st_q <= ST_D3;
				end
				ST_D3: if (dstat.done) st_q <= ST_RD;
				ST_RD: begin
					two_q <= two_c;
					err_q <= bank_q >= XW'(NUM_BANKS);
					bank_index <= bank_q[6:0];
					bank_error <= bank_q >= XW'(NUM_BANKS);
					st_q <= ST_UPD;
				end
				ST_UPD: begin
					if (!err_q) begin
						if (two_q) begin
							if (op_q == OP_WRITE) w2_q <= w2_q + 32'd1;
							else r2_q <= r2_q + 32'd1;
						end else begin
							if (op_q == OP_WRITE) w1_q <= w1_q + 32'd1;
							else r1_q <= r1_q + 32'd1;
						end
					end
					st_q <= ST_D4;
				end
				ST_D4: if (dstat.done) st_q <= ST_OUT;
				ST_OUT: begin
					if (two_q && pt_q > {24'd0, acc_e} + {24'd0, dly_q} && arm2_q) begin
						arm2_q <= 1'b0; arm1_q <= 1'b1; rclosed_q <= 1'b0;
						snapshot_taken <= 1'b1; closed_phase <= 1'b0;
						interval_start <= start_q;
						closed_reads <= r1_q; closed_writes <= w1_q;
						closed_total <= r1_q + w1_q;
						skipped_intervals <= (start_q > last_q) ? quo : 48'd0;
						r1_q <= '0; w1_q <= '0; last_q <= start_q;
						cidx_q <= '0; st_q <= ST_CRD;
					end else if (!two_q && pt_q > {24'd0, dly_q} && arm1_q) begin
						arm1_q <= 1'b0; arm2_q <= 1'b1; rclosed_q <= 1'b1;
						snapshot_taken <= 1'b1; closed_phase <= 1'b1;
						interval_start <= start_q;
						closed_reads <= r2_q; closed_writes <= w2_q;
						closed_total <= r2_q + w2_q;
						skipped_intervals <= (start_q > last_q) ? quo : 48'd0;
						r2_q <= '0; w2_q <= '0; last_q <= start_q;
						cidx_q <= '0; st_q <= ST_CRD;
					end else begin
						done <= 1'b1; st_q <= ST_IDLE;
					end
				end
				ST_CRD: begin
					cidx_q <= cidx_q + 1'b1;
					st_q <= ST_COPY;
				end
				ST_COPY: begin
					cidx_q <= cidx_q + 1'b1;
					if (cidx_q == (BW+1)'(NUM_BANKS)) begin
						done <= 1'b1; st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// interval start is time minus time modulo accumulation time
	logic [47:0] t_rem_q;
	always_ff @(posedge clk) begin
		if (st_q == ST_D3 && dstat.done) t_rem_q <= {22'd0, rem};
		if (st_q == ST_RD) start_q <= t_q - t_rem_q;
	end

	// phase memory read and write
	logic [BW:0] prd_addr;
	always_comb begin
		prd_addr = paddr;
		if (st_q == ST_COPY || st_q == ST_CRD)
			prd_addr = {rclosed_q, cidx_q[BW-1:0]};
	end

	// copy one entry per cycle into the snapshot and clear it behind the read
	always_ff @(posedge clk) begin
		prd_q <= pcnt_mem[prd_addr];
		srd_q <= snap_mem[saddr];
		if (st_q == ST_CLR) begin
			pcnt_mem[cidx_q] <= 32'd0;
			snap_mem[cidx_q[BW-1:0]] <= 32'd0;
		end else if (st_q == ST_UPD && !err_q) begin
			pcnt_mem[paddr] <= prd_q + 32'd1;
		end else if (st_q == ST_COPY) begin
			pcnt_mem[{rclosed_q, copy_a}] <= 32'd0;
			snap_mem[copy_a] <= prd_q;
		end
	end

	assign busy = (st_q != ST_IDLE);
endmodule
`default_nettype wire

// ===== rtl/dbam_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on dbam_pkg.
`default_nettype none
module dbam_div #(
	parameter int NW = 48,
	parameter int DW = 26
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic [NW-1:0]     num,
	input  wire logic [DW-1:0]     den,
	output dbam_pkg::div_stat_t    stat,
	output logic [NW-1:0]          quo,
	output logic [DW-1:0]          rem
);
	import dbam_pkg::*;
	localparam int CW = $clog2(NW + 1);
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] q_q;
	logic [DW-1:0] r_q, d_q;
	logic          busy_q, done_q;
	logic [DW:0]   sh;
	logic [DW:0]   diff;

	assign sh   = {r_q, q_q[NW-1]};
	assign diff = sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				r_q <= diff[DW-1:0];
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= sh[DW-1:0];
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo = q_q;
	assign rem = r_q;
endmodule
`default_nettype wire
